### rtl/assert_macros.svh
// assertion macros shared by the scheduler rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CES_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define CES_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/ces_pkg.sv
// shared types and constants for the cycle event scheduler
// no dependencies
package ces_pkg;

	localparam int NUM_TASKS  = 8;
	localparam int COUNT_BITS = 32;
	localparam int IDX_BITS   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int STEP_BITS  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam int MASK_BITS  = (NUM_TASKS > 8) ? NUM_TASKS : 8;

	// item modes
	typedef enum logic [1:0] {
		MODE_CLEAR    = 2'd0,
		MODE_SCHEDULE = 2'd1,
		MODE_FIRE     = 2'd2,
		MODE_ADVANCE  = 2'd3
	} mode_t;

	typedef logic [2:0]  task_id_t;
	typedef logic [30:0] delay_t;
	typedef logic [31:0] word_t;
	typedef logic [7:0]  fired_mask_t;

endpackage

### rtl/ces_if.sv
// valid/ready channels for scheduler items and results
// depends on ces_pkg
interface ces_req_if;
	logic                     valid;
	logic                     ready;
	ces_pkg::mode_t           mode;
	ces_pkg::task_id_t        task_id;
	ces_pkg::delay_t          delay;
	logic signed [31:0]       cycles_remaining;
	ces_pkg::word_t           max_step;

	modport source (output valid, mode, task_id, delay, cycles_remaining, max_step,
		input ready);
	modport sink (input valid, mode, task_id, delay, cycles_remaining, max_step,
		output ready);
endinterface

interface ces_rsp_if;
	logic                     valid;
	logic                     ready;
	ces_pkg::fired_mask_t     fired_mask;
	ces_pkg::word_t           step;
	logic                     load_remaining;
	ces_pkg::delay_t          remaining_value;
	ces_pkg::word_t           event_count;

	modport source (output valid, fired_mask, step, load_remaining, remaining_value,
		event_count, input ready);
	modport sink (input valid, fired_mask, step, load_remaining, remaining_value,
		event_count, output ready);
endinterface

### rtl/cycle_event_scheduler.sv
// cycle event scheduler top level: deadline memory, scan sequencer, result register
// depends on ces_pkg, ces_if.sv and assert_macros.svh
`include "assert_macros.svh"

// One item is in flight at a time; a new beat is taken whenever the sequencer is
// idle, even while the last result still waits in the output register. The task
// deadlines sit in a synchronous memory with one write port and one read per cycle,
// so the scan over NUM_TASKS entries sets the rate of fire and advance items. Clear
// goes straight to the result state, schedule subtracts, then adds and writes, fire
// scans and drains, and advance scans, drains and adds the step before the output
// register is loaded. Deadlines need no reset: an entry is compared only when its active
// bit, which reset clears, shows that it was written.
module cycle_event_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	ces_req_if.sink        req,
	ces_rsp_if.source      rsp
);

	localparam int NT = ces_pkg::NUM_TASKS;
	localparam int CB = ces_pkg::COUNT_BITS;
	localparam int IB = ces_pkg::IDX_BITS;
	localparam int SB = ces_pkg::STEP_BITS;
	localparam int MB = ces_pkg::MASK_BITS;

	typedef enum logic [6:0] {
		S_IDLE       = 7'b0000001,
		S_SCHED_BASE = 7'b0000010,
		S_SCHED_WR   = 7'b0000100,
		S_SCAN       = 7'b0001000,
		S_DRAIN      = 7'b0010000,
		S_ADVANCE    = 7'b0100000,
		S_RESULT     = 7'b1000000
	} state_t;

	state_t                 state_q;
	ces_pkg::mode_t         mode_q;
	logic [IB-1:0]          tid_q;
	ces_pkg::delay_t        delay_q;
	logic [CB-1:0]          rem_q;
	logic                   reload_q;
	logic [CB-1:0]          base_s1;
	logic [NT-1:0]          active_q;
	logic [NT-1:0]          fired_q;
	logic [CB-1:0]          nec_q;
	logic [SB-1:0]          best_q;
	logic [IB-1:0]          scan_idx_q;
	logic                   rd_valid_s1;
	logic [IB-1:0]          rd_idx_s1;
	logic [CB-1:0]          rd_data_s1;

	logic [CB-1:0]          mem [NT];
	logic                   mem_we;
	logic [CB-1:0]          mem_wdata;

	logic                   out_valid_q;
	ces_pkg::fired_mask_t   fired_mask_q;
	ces_pkg::word_t         step_q;
	logic                   load_q;
	ces_pkg::delay_t        remval_q;
	ces_pkg::word_t         event_count_q;

	logic                   in_beat;
	logic                   tid_ok;
	logic                   reload_now;
	logic [CB-1:0]          wrap_gap;
	logic [MB-1:0]          fired_wide;

	// handshake
	assign req.ready = (state_q == S_IDLE);
	assign in_beat   = req.valid && req.ready;

	// item decode at the input beat
	assign tid_ok     = 32'(req.task_id) < 32'(NT);
	assign reload_now = (req.mode == ces_pkg::MODE_SCHEDULE) && tid_ok &&
		($signed(req.cycles_remaining) > $signed({1'b0, req.delay}));

	// deadline memory write port
	assign mem_we    = (state_q == S_SCHED_WR);
	assign mem_wdata = base_s1 + CB'(delay_q);

	// wrapped distance from the event count to the deadline being scanned
	assign wrap_gap   = rd_data_s1 - nec_q;
	assign fired_wide = MB'(fired_q);

	// deadline memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tid_q] <= mem_wdata;
		end
		rd_data_s1 <= mem[scan_idx_q];
	end

	// payload registers without reset
	always_ff @(posedge clk) begin
		if (in_beat) begin
			mode_q  <= req.mode;
			tid_q   <= IB'(req.task_id);
			delay_q <= req.delay;
			rem_q   <= CB'(req.cycles_remaining);
		end
		if (state_q == S_SCHED_BASE) begin
			base_s1 <= nec_q - rem_q;
		end
		rd_idx_s1 <= scan_idx_q;
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			active_q      <= '0;
			fired_q       <= '0;
			nec_q         <= '0;
			best_q        <= '0;
			reload_q      <= 1'b0;
			scan_idx_q    <= '0;
			rd_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
			fired_mask_q  <= '0;
			step_q        <= '0;
			load_q        <= 1'b0;
			remval_q      <= '0;
			event_count_q <= '0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);

			// result taken downstream, unless the next one is loaded in its place
			if (out_valid_q && rsp.ready && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end

			// compare one scanned deadline
			if (rd_valid_s1 && active_q[rd_idx_s1]) begin
				if (mode_q == ces_pkg::MODE_FIRE && rd_data_s1 == nec_q) begin
					active_q[rd_idx_s1] <= 1'b0;
					fired_q[rd_idx_s1]  <= 1'b1;
				end
				if (mode_q == ces_pkg::MODE_ADVANCE && SB'(wrap_gap) < best_q) begin
					best_q <= SB'(wrap_gap);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						fired_q    <= '0;
						best_q     <= SB'(req.max_step);
						reload_q   <= reload_now;
						scan_idx_q <= '0;
						case (req.mode)
							ces_pkg::MODE_CLEAR: begin
								active_q <= '0;
								state_q  <= S_RESULT;
							end
							ces_pkg::MODE_SCHEDULE: begin
								state_q <= tid_ok ? S_SCHED_BASE : S_RESULT;
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCHED_BASE: begin
					state_q <= S_SCHED_WR;
				end
				S_SCHED_WR: begin
					active_q[tid_q] <= 1'b1;
					if (reload_q) begin
						nec_q <= mem_wdata;
					end
					state_q <= S_RESULT;
				end
				S_SCAN: begin
					if (scan_idx_q == IB'(NT - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= (mode_q == ces_pkg::MODE_ADVANCE) ? S_ADVANCE : S_RESULT;
				end
				S_ADVANCE: begin
					nec_q   <= nec_q + CB'(best_q);
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q   <= 1'b1;
						fired_mask_q  <= fired_wide[7:0];
						step_q        <= (mode_q == ces_pkg::MODE_ADVANCE) ? 32'(best_q) : '0;
						load_q        <= reload_q;
						remval_q      <= reload_q ? delay_q : '0;
						event_count_q <= 32'(nec_q);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result channel
	assign rsp.valid           = out_valid_q;
	assign rsp.fired_mask      = fired_mask_q;
	assign rsp.step            = step_q;
	assign rsp.load_remaining  = load_q;
	assign rsp.remaining_value = remval_q;
	assign rsp.event_count     = event_count_q;

	// checks
	`CES_ASSERT(a_result_from_seq, $rose(out_valid_q) |-> $past(state_q == S_RESULT), "result loaded outside result state")
	`CES_ASSERT(a_read_in_scan, rd_valid_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN), "deadline read outside scan")
	`CES_ASSERT_NEVER(a_fired_still_active, state_q == S_RESULT && (fired_q & active_q) != '0, "fired task left active")
	`CES_ASSERT(a_count_moves, nec_q != $past(nec_q) |-> ($past(state_q == S_SCHED_WR) || $past(state_q == S_ADVANCE)), "event count changed outside schedule or advance")

endmodule
